>>> rtl/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared widths, sizes, register indexes and request codes.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int POOL_BITS      = 16;
   localparam int MIN_BLOCK_BITS = 4;
   localparam int FREE_DEPTH     = 8192;
   localparam int NUM_LEVELS     = POOL_BITS + 1;

   localparam int OFF_W   = 16;
   localparam int SIZE_W  = 17;
   localparam int LVL_W   = 5;
   localparam int CNT_W   = 14;
   localparam int ADDR_W  = 13;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // register indexes (byte address bit 2)
   localparam logic CSR_MIN_LEVEL  = 1'b0;
   localparam logic CSR_POOL_LEVEL = 1'b1;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } opcode_type;

endpackage : bba_pkg
`default_nettype wire

>>> rtl/bba_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate or release request.
// ----------------------------------------------------------------------------
interface bba_req_if
   import bba_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                opcode;
   logic [SIZE_W-1:0]   size_bytes;
   logic [OFF_W-1:0]    block_offset;

   modport source (output valid, opcode, size_bytes, block_offset, input ready);
   modport sink   (input valid, opcode, size_bytes, block_offset, output ready);
endinterface : bba_req_if
`default_nettype wire

>>> rtl/bba_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface bba_rsp_if
   import bba_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              success;
   logic [OFF_W-1:0]  result_offset;

   modport source (output valid, success, result_offset, input ready);
   modport sink   (input valid, success, result_offset, output ready);
endinterface : bba_rsp_if
`default_nettype wire

>>> rtl/buddy_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy block allocator
// Power-of-two allocator keeping one free list per level.
// ----------------------------------------------------------------------------
// One request is handled at a time by a sequencer around one 8192 x 16
// free-list memory (one write, one registered read per cycle). All lists
// sit back to back in the memory, so a list's start is summed from the level
// counts one level per cycle, and every insert or removal moves the tail of
// the memory one entry at a time, through a read state and a write state.
// An allocate searches the levels, removes the popped block and pushes each
// split half; a release scans for the buddy and removes it at each merge
// step, then makes one final insert. After reset the block seeds the pool in
// its init state before taking requests; a configuration write reseeds the
// pool the same way. Results leave through an output register, so a new
// request is taken while the previous result still waits.
// ----------------------------------------------------------------------------
module buddy_block_allocator
   import bba_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   bba_req_if.sink                req_ch,
   bba_rsp_if.source              rsp_ch,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [15:0] {
      S_INIT     = 16'h0001,
      S_IDLE     = 16'h0002,
      S_ACC      = 16'h0004,
      S_SEARCH   = 16'h0008,
      S_GETBLK   = 16'h0010,
      S_RMV_RD   = 16'h0020,
      S_RMV_WR   = 16'h0040,
      S_PUSHNEXT = 16'h0080,
      S_PUSHGO   = 16'h0100,
      S_PSH_RD   = 16'h0200,
      S_PSH_WR   = 16'h0400,
      S_PSH_PUT  = 16'h0800,
      S_MERGE    = 16'h1000,
      S_SCAN_RD  = 16'h2000,
      S_SCAN_CMP = 16'h4000,
      S_DONE     = 16'h8000
   } state_type;

   typedef enum logic [1:0] {
      P_SEARCH = 2'd0,
      P_PUSH   = 2'd1,
      P_SCAN   = 2'd2
   } purp_type;

   state_type         state_ff, state_in;
   purp_type          purp_ff, purp_in;
   logic              op_ff, op_in;
   logic [LVL_W-1:0]  lv_ff, lv_in;
   logic [LVL_W-1:0]  i_ff, i_in;
   logic [LVL_W-1:0]  j_ff, j_in;
   logic [LVL_W-1:0]  lim_ff, lim_in;
   logic [LVL_W-1:0]  plv_ff, plv_in;
   logic [OFF_W-1:0]  blk_ff, blk_in;
   logic [OFF_W-1:0]  cur_ff, cur_in;
   logic [OFF_W-1:0]  buddy_ff, buddy_in;
   logic [OFF_W-1:0]  pval_ff, pval_in;
   logic [CNT_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  end_ff, end_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  counts_ff [NUM_LEVELS];
   logic [CNT_W-1:0]  counts_in [NUM_LEVELS];
   logic [LVL_W-1:0]  min_ff, min_in;
   logic [LVL_W-1:0]  pool_ff, pool_in;
   logic              ok_ff, ok_in;
   logic [OFF_W-1:0]  res_ff, res_in;
   logic              rv_ff, rv_in;
   logic              rok_ff, rok_in;
   logic [OFF_W-1:0]  roff_ff, roff_in;

   logic [OFF_W-1:0]  mem [FREE_DEPTH];
   logic [OFF_W-1:0]  rd_q_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [OFF_W-1:0]  wdata;

   logic [LVL_W-1:0]  lv_req;
   logic              req_acc;
   logic              cfg_wr;
   logic [LVL_W-1:0]  cfg_v;
   logic [SIZE_W-1:0] pmask;
   logic [SIZE_W-1:0] bmask;

   bba_size_level u_level (
      .size_bytes (req_ch.size_bytes),
      .min_level  (min_ff),
      .level      (lv_req)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign cfg_wr       = csr_psel && csr_penable && csr_pwrite;
   assign cfg_v        = csr_pwdata[LVL_W-1:0];
   assign csr_pready   = 1'b1;
   assign csr_prdata   = (csr_paddr[2] == CSR_POOL_LEVEL) ? CSR_DW'(pool_ff) : CSR_DW'(min_ff);

   assign rsp_ch.valid         = rv_ff;
   assign rsp_ch.success       = rok_ff;
   assign rsp_ch.result_offset = roff_ff;

   assign pmask = (SIZE_W'(1) << pool_ff) - SIZE_W'(1);
   assign bmask = (SIZE_W'(1) << lv_req) - SIZE_W'(1);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      purp_in   = purp_ff;
      op_in     = op_ff;
      lv_in     = lv_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      lim_in    = lim_ff;
      plv_in    = plv_ff;
      blk_in    = blk_ff;
      cur_in    = cur_ff;
      buddy_in  = buddy_ff;
      pval_in   = pval_ff;
      acc_in    = acc_ff;
      k_in      = k_ff;
      end_in    = end_ff;
      pos_in    = pos_ff;
      used_in   = used_ff;
      counts_in = counts_ff;
      min_in    = min_ff;
      pool_in   = pool_ff;
      ok_in     = ok_ff;
      res_in    = res_ff;
      rok_in    = rok_ff;
      roff_in   = roff_ff;
      rv_in     = rv_ff && !rsp_ch.ready;
      we        = 1'b0;
      waddr     = '0;
      wdata     = '0;
      rd_addr   = '0;

      unique case (state_ff)
         S_INIT: begin
            // seed the single pool block at offset zero
            we       = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               op_in  = req_ch.opcode;
               lv_in  = lv_req;
               i_in   = lv_req;
               lim_in = lv_req;
               acc_in = '0;
               j_in   = '0;
               ok_in  = 1'b0;
               res_in = '0;
               if (lv_req > pool_ff) begin
                  state_in = S_DONE;
               end else if (req_ch.opcode == OP_ALLOC) begin
                  purp_in  = P_SEARCH;
                  state_in = S_ACC;
               end else begin
                  cur_in   = req_ch.block_offset & pmask[OFF_W-1:0] & ~bmask[OFF_W-1:0];
                  state_in = S_MERGE;
               end
            end
         end
         S_ACC: begin
            // sum the lengths of the lists below the limit level
            if (j_ff == lim_ff) begin
               case (purp_ff)
                  P_SEARCH: state_in = S_SEARCH;
                  P_PUSH: begin
                     pos_in   = acc_ff;
                     k_in     = used_ff;
                     state_in = S_PSH_RD;
                  end
                  P_SCAN: begin
                     k_in     = acc_ff;
                     end_in   = acc_ff + counts_ff[lv_ff];
                     state_in = S_SCAN_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end else begin
               acc_in = acc_ff + counts_ff[j_ff];
               j_in   = j_ff + LVL_W'(1);
            end
         end
         S_SEARCH: begin
            // walk up the levels to the first non-empty list
            if (counts_ff[i_ff] != '0) begin
               rd_addr  = acc_ff[ADDR_W-1:0];
               pos_in   = acc_ff;
               state_in = S_GETBLK;
            end else if (i_ff == pool_ff) begin
               state_in = S_DONE;
            end else begin
               acc_in = acc_ff + counts_ff[i_ff];
               i_in   = i_ff + LVL_W'(1);
            end
         end
         S_GETBLK: begin
            blk_in            = rd_q_ff;
            counts_in[i_ff]   = counts_ff[i_ff] - CNT_W'(1);
            used_in           = used_ff - CNT_W'(1);
            k_in              = pos_ff;
            state_in          = S_RMV_RD;
         end
         S_RMV_RD: begin
            // close the gap: move the tail down one entry
            if (k_ff == used_ff) begin
               state_in = (op_ff == OP_ALLOC) ? S_PUSHNEXT : S_MERGE;
            end else begin
               rd_addr  = ADDR_W'(k_ff + CNT_W'(1));
               state_in = S_RMV_WR;
            end
         end
         S_RMV_WR: begin
            we       = 1'b1;
            waddr    = k_ff[ADDR_W-1:0];
            wdata    = rd_q_ff;
            k_in     = k_ff + CNT_W'(1);
            state_in = S_RMV_RD;
         end
         S_PUSHNEXT: begin
            // split off upper halves from high level to low
            if (i_ff > lv_ff) begin
               plv_in   = i_ff - LVL_W'(1);
               pval_in  = blk_ff + (OFF_W'(1) << (i_ff - LVL_W'(1)));
               i_in     = i_ff - LVL_W'(1);
               state_in = S_PUSHGO;
            end else begin
               ok_in    = 1'b1;
               res_in   = blk_ff;
               state_in = S_DONE;
            end
         end
         S_PUSHGO: begin
            // drop the push when the store is full
            if (used_ff[CNT_W-1]) begin
               if (op_ff == OP_ALLOC) begin
                  state_in = S_PUSHNEXT;
               end else begin
                  ok_in    = 1'b1;
                  res_in   = '0;
                  state_in = S_DONE;
               end
            end else begin
               acc_in   = '0;
               j_in     = '0;
               lim_in   = plv_ff + LVL_W'(1);
               purp_in  = P_PUSH;
               state_in = S_ACC;
            end
         end
         S_PSH_RD: begin
            // open a slot: move the tail up one entry
            if (k_ff == pos_ff) begin
               state_in = S_PSH_PUT;
            end else begin
               rd_addr  = ADDR_W'(k_ff - CNT_W'(1));
               state_in = S_PSH_WR;
            end
         end
         S_PSH_WR: begin
            we       = 1'b1;
            waddr    = k_ff[ADDR_W-1:0];
            wdata    = rd_q_ff;
            k_in     = k_ff - CNT_W'(1);
            state_in = S_PSH_RD;
         end
         S_PSH_PUT: begin
            we                = 1'b1;
            waddr             = pos_ff[ADDR_W-1:0];
            wdata             = pval_ff;
            counts_in[plv_ff] = counts_ff[plv_ff] + CNT_W'(1);
            used_in           = used_ff + CNT_W'(1);
            if (op_ff == OP_ALLOC) begin
               state_in = S_PUSHNEXT;
            end else begin
               ok_in    = 1'b1;
               res_in   = '0;
               state_in = S_DONE;
            end
         end
         S_MERGE: begin
            // look for the buddy while below the pool level
            if (lv_ff < pool_ff) begin
               buddy_in = cur_ff ^ (OFF_W'(1) << lv_ff);
               acc_in   = '0;
               j_in     = '0;
               lim_in   = lv_ff;
               purp_in  = P_SCAN;
               state_in = S_ACC;
            end else begin
               plv_in   = lv_ff;
               pval_in  = cur_ff;
               state_in = S_PUSHGO;
            end
         end
         S_SCAN_RD: begin
            if (k_ff == end_ff) begin
               plv_in   = lv_ff;
               pval_in  = cur_ff;
               state_in = S_PUSHGO;
            end else begin
               rd_addr  = k_ff[ADDR_W-1:0];
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (rd_q_ff == buddy_ff) begin
               counts_in[lv_ff] = counts_ff[lv_ff] - CNT_W'(1);
               used_in          = used_ff - CNT_W'(1);
               if (buddy_ff < cur_ff) begin
                  cur_in = buddy_ff;
               end
               lv_in    = lv_ff + LVL_W'(1);
               state_in = S_RMV_RD;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_DONE: begin
            // hand the result to the output register when it is free
            if (!rv_ff || rsp_ch.ready) begin
               rv_in    = 1'b1;
               rok_in   = ok_ff;
               roff_in  = res_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // register write reseeds the pool
      if (cfg_wr && (csr_paddr[2] == CSR_MIN_LEVEL || csr_paddr[2] == CSR_POOL_LEVEL)) begin
         if (csr_paddr[2] == CSR_MIN_LEVEL) begin
            min_in = cfg_v;
         end else begin
            pool_in = (cfg_v > LVL_W'(POOL_BITS)) ? LVL_W'(POOL_BITS) : cfg_v;
         end
         for (int n = 0; n < NUM_LEVELS; n++) begin
            counts_in[n] = '0;
         end
         counts_in[pool_in] = CNT_W'(1);
         used_in            = CNT_W'(1);
         state_in           = S_INIT;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         rv_ff    <= 1'b0;
         used_ff  <= CNT_W'(1);
         min_ff   <= LVL_W'(MIN_BLOCK_BITS);
         pool_ff  <= LVL_W'(POOL_BITS);
         for (int n = 0; n < NUM_LEVELS; n++) begin
            counts_ff[n] <= (n == POOL_BITS) ? CNT_W'(1) : '0;
         end
      end else begin
         state_ff  <= state_in;
         rv_ff     <= rv_in;
         used_ff   <= used_in;
         min_ff    <= min_in;
         pool_ff   <= pool_in;
         counts_ff <= counts_in;
      end
      purp_ff  <= purp_in;
      op_ff    <= op_in;
      lv_ff    <= lv_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      lim_ff   <= lim_in;
      plv_ff   <= plv_in;
      blk_ff   <= blk_in;
      cur_ff   <= cur_in;
      buddy_ff <= buddy_in;
      pval_ff  <= pval_in;
      acc_ff   <= acc_in;
      k_ff     <= k_in;
      end_ff   <= end_in;
      pos_ff   <= pos_in;
      ok_ff    <= ok_in;
      res_ff   <= res_in;
      rok_ff   <= rok_in;
      roff_ff  <= roff_in;
   end

   // free-list memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(FREE_DEPTH))
      else $error("free store count past depth");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_acc && !cfg_wr |=> state_ff != S_IDLE)
      else $error("request taken but sequencer idle");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PSH_PUT && !cfg_wr |=> used_ff == $past(used_ff) + CNT_W'(1))
      else $error("insert did not grow the store");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rok_ff |-> roff_ff == '0)
      else $error("failed request returned an offset");

endmodule : buddy_block_allocator
`default_nettype wire

>>> rtl/bba_size_level.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Size to level
// Rounds a byte size up to a power-of-two level, floored at min_level.
// ----------------------------------------------------------------------------
module bba_size_level
   import bba_pkg::*;
(
   input  wire logic [SIZE_W-1:0] size_bytes,
   input  wire logic [LVL_W-1:0]  min_level,
   output logic      [LVL_W-1:0]  level
);

   logic [SIZE_W-1:0] size_m1;
   logic [LVL_W-1:0]  msb;
   logic [LVL_W-1:0]  raw;

   // find the top set bit of size - 1
   always_comb begin
      size_m1 = size_bytes - SIZE_W'(1);
      msb     = '0;
      for (int b = 0; b < SIZE_W; b++) begin
         if (size_m1[b]) begin
            msb = LVL_W'(b);
         end
      end
      raw   = (size_bytes <= SIZE_W'(1)) ? '0 : msb + LVL_W'(1);
      level = (raw < min_level) ? min_level : raw;
   end

endmodule : bba_size_level
`default_nettype wire
